// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("assertion failed");

// Check that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

`endif

// ===== src/rafb_pkg.sv =====
// Types and constants of the radio API frame builder.
package rafb_pkg;

   localparam int MAX_PAYLOAD = 256;
   localparam int LEN_W       = 9;
   localparam int CNT_W       = $clog2(MAX_PAYLOAD + 2);
   localparam int CMP_W       = (CNT_W > LEN_W) ? CNT_W : LEN_W;

   // keep the queue depth a power of two so the pointers wrap on their own
   localparam int QDEPTH = 2;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   localparam int TX_HDR_LEN    = 17;
   localparam int AT_HDR_LEN    = 7;
   localparam int STEP_W        = $clog2(TX_HDR_LEN);
   localparam int HDR_SUM_START = 3;

   localparam logic [7:0]  START_BYTE   = 8'h7E;
   localparam logic [7:0]  TYPE_TX      = 8'h10;
   localparam logic [7:0]  TYPE_AT      = 8'h08;
   localparam logic [7:0]  CSUM_BASE    = 8'hFF;
   localparam logic [15:0] LEN_BASE_TX  = 16'd14;
   localparam logic [15:0] LEN_BASE_AT  = 16'd4;

   localparam logic [63:0] DEST_RESET   = 64'h0;
   localparam logic [15:0] NET_RESET    = 16'hFFFE;
   localparam logic [7:0]  TX_ID_RESET  = 8'h44;
   localparam logic [7:0]  AT_ID_RESET  = 8'h55;

   localparam logic KIND_TX = 1'b0;
   localparam logic KIND_AT = 1'b1;

   localparam int CSR_ADDR_W = 5;

   typedef enum logic [1:0] {
      REG_DEST   = 2'd0,
      REG_NET    = 2'd1,
      REG_TX_ID  = 2'd2,
      REG_AT_ID  = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic              kind;
      logic              hdr;
      logic              emit_data;
      logic              emit_sum;
      logic              mis;
      logic [LEN_W-1:0]  plen;
      logic [15:0]       at_code;
      logic [7:0]        data_byte;
   } entry_type;

   typedef struct packed {
      logic push;
      logic pop;
   } q_ctrl_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_status_type;

   typedef struct packed {
      logic [63:0] dest;
      logic [15:0] net;
      logic [7:0]  tx_id;
      logic [7:0]  at_id;
   } cfg_type;

endpackage

// ===== src/rafb_front.sv =====
// Front end: accepts input words, tracks frame state and classifies the work.
module rafb_front
   import rafb_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_command,
   input  logic               req_first_item,
   input  logic               req_last_item,
   input  logic               req_has_data,
   input  logic [LEN_W-1:0]   req_payload_length,
   input  logic [15:0]        req_at_code,
   input  logic [7:0]         req_data_byte,
   input  q_status_type       q_status,
   output logic               push,
   output entry_type          entry
);

   logic              in_frame_ff, in_frame_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [LEN_W-1:0]  decl_ff, decl_in;

   logic              accept;
   logic              open;
   logic [CNT_W-1:0]  cnt_base;
   logic              room;
   logic              bump;

   always_comb begin
      accept   = req_valid && req_ready;
      open     = req_first_item || in_frame_ff;
      cnt_base = req_first_item ? '0 : count_ff;
      room     = cnt_base < CNT_W'(MAX_PAYLOAD);
      // count one overflow byte so the checksum flags the mismatch
      bump     = open && req_has_data && (cnt_base <= CNT_W'(MAX_PAYLOAD));
      count_in = bump ? cnt_base + 1'b1 : cnt_base;
      decl_in  = req_first_item ? req_payload_length : decl_ff;
      in_frame_in = open && !req_last_item;

      entry.kind      = req_command;
      entry.hdr       = req_first_item;
      entry.emit_data = open && req_has_data && room;
      entry.emit_sum  = open && req_last_item;
      entry.mis       = CMP_W'(count_in) != CMP_W'(decl_in);
      entry.plen      = req_payload_length;
      entry.at_code   = req_at_code;
      entry.data_byte = req_data_byte;

      push = accept && (entry.hdr || entry.emit_data || entry.emit_sum);
   end

   assign req_ready = !q_status.full;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         count_ff    <= '0;
         decl_ff     <= '0;
      end else if (accept) begin
         in_frame_ff <= in_frame_in;
         count_ff    <= count_in;
         decl_ff     <= decl_in;
      end
   end

endmodule

// ===== src/rafb_queue.sv =====
// Short queue of classified words between the front and back ends.
module rafb_queue
   import rafb_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  q_ctrl_type    ctrl,
   input  entry_type     wr_entry,
   output entry_type     rd_entry,
   output q_status_type  status
);

   entry_type          mem_ff [QDEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]  count_ff;

   assign rd_entry     = mem_ff[rd_ptr_ff];
   assign status.empty = count_ff == '0;
   assign status.full  = count_ff == QCNT_W'(QDEPTH);

   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         mem_ff[wr_ptr_ff] <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (ctrl.push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (ctrl.pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         case ({ctrl.push, ctrl.pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

// ===== src/rafb_back.sv =====
// Back end: sequences header, data and checksum bytes into the output register.
module rafb_back
   import rafb_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  q_status_type  q_status,
   input  entry_type     q_entry,
   output logic          pop,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic [7:0]    rsp_out_byte,
   output logic          rsp_frame_last,
   output logic          rsp_length_mismatch
);

   typedef enum logic [3:0] {
      PH_IDLE = 4'b0001,
      PH_HDR  = 4'b0010,
      PH_DATA = 4'b0100,
      PH_SUM  = 4'b1000
   } phase_type;

   phase_type          phase_ff, phase_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [7:0]         sum_ff, sum_in;
   entry_type          cur_ff;

   logic               out_valid_ff, out_valid_in;
   logic [7:0]         out_byte_ff, out_byte_in;
   logic               out_last_ff, out_last_in;
   logic               out_mis_ff, out_mis_in;

   logic [7:0]         tx_hdr [TX_HDR_LEN];
   logic [7:0]         at_hdr [AT_HDR_LEN];
   logic [15:0]        len;
   logic [STEP_W-1:0]  hdr_last;
   logic [7:0]         hdr_byte;
   logic               advance, emit, done, load;
   phase_type          next_phase;

   function automatic phase_type first_phase(input entry_type e);
      phase_type p;
      if (e.hdr) begin
         p = PH_HDR;
      end else if (e.emit_data) begin
         p = PH_DATA;
      end else begin
         p = PH_SUM;
      end
      return p;
   endfunction

   always_comb begin
      len = {{(16 - LEN_W){1'b0}}, cur_ff.plen}
            + ((cur_ff.kind == KIND_AT) ? LEN_BASE_AT : LEN_BASE_TX);

      tx_hdr[0]  = START_BYTE;
      tx_hdr[1]  = len[15:8];
      tx_hdr[2]  = len[7:0];
      tx_hdr[3]  = TYPE_TX;
      tx_hdr[4]  = cfg.tx_id;
      for (int i = 0; i < 8; i++) begin
         tx_hdr[5 + i] = cfg.dest[63 - 8 * i -: 8];
      end
      tx_hdr[13] = cfg.net[15:8];
      tx_hdr[14] = cfg.net[7:0];
      tx_hdr[15] = 8'h00;
      tx_hdr[16] = 8'h00;

      at_hdr[0]  = START_BYTE;
      at_hdr[1]  = len[15:8];
      at_hdr[2]  = len[7:0];
      at_hdr[3]  = TYPE_AT;
      at_hdr[4]  = cfg.at_id;
      at_hdr[5]  = cur_ff.at_code[15:8];
      at_hdr[6]  = cur_ff.at_code[7:0];

      if (cur_ff.kind == KIND_AT) begin
         hdr_last = STEP_W'(AT_HDR_LEN - 1);
         hdr_byte = at_hdr[step_ff[2:0]];
      end else begin
         hdr_last = STEP_W'(TX_HDR_LEN - 1);
         hdr_byte = tx_hdr[step_ff];
      end
   end

   always_comb begin
      advance    = !out_valid_ff || rsp_ready;
      emit       = advance && (phase_ff != PH_IDLE);
      done       = 1'b0;
      next_phase = phase_ff;
      step_in    = step_ff;
      sum_in     = sum_ff;
      out_byte_in = out_byte_ff;
      out_last_in = 1'b0;
      out_mis_in  = 1'b0;

      case (phase_ff)
         PH_HDR: begin
            out_byte_in = hdr_byte;
            if (step_ff == '0) begin
               sum_in = '0;
            end else if (step_ff >= STEP_W'(HDR_SUM_START)) begin
               sum_in = sum_ff + hdr_byte;
            end
            if (step_ff == hdr_last) begin
               step_in = '0;
               if (cur_ff.emit_data) begin
                  next_phase = PH_DATA;
               end else if (cur_ff.emit_sum) begin
                  next_phase = PH_SUM;
               end else begin
                  done = 1'b1;
               end
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         PH_DATA: begin
            out_byte_in = cur_ff.data_byte;
            sum_in      = sum_ff + cur_ff.data_byte;
            if (cur_ff.emit_sum) begin
               next_phase = PH_SUM;
            end else begin
               done = 1'b1;
            end
         end
         PH_SUM: begin
            out_byte_in = CSUM_BASE - sum_ff;
            out_last_in = 1'b1;
            out_mis_in  = cur_ff.mis;
            done        = 1'b1;
         end
         default: begin
            out_byte_in = out_byte_ff;
         end
      endcase

      load = !q_status.empty && ((phase_ff == PH_IDLE) || (emit && done));
      pop  = load;

      if (load) begin
         phase_in = first_phase(q_entry);
      end else if (emit && done) begin
         phase_in = PH_IDLE;
      end else if (emit) begin
         phase_in = next_phase;
      end else begin
         phase_in = phase_ff;
      end

      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         step_ff      <= '0;
         sum_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         out_valid_ff <= out_valid_in;
         if (emit) begin
            step_ff <= step_in;
            sum_ff  <= sum_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cur_ff <= q_entry;
      end
      if (emit) begin
         out_byte_ff <= out_byte_in;
         out_last_ff <= out_last_in;
         out_mis_ff  <= out_mis_in;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_out_byte        = out_byte_ff;
   assign rsp_frame_last      = out_last_ff;
   assign rsp_length_mismatch = out_mis_ff;

endmodule

// ===== src/radio_api_frame_builder.sv =====
// Top level of the radio API frame builder: registers, front, queue and back.
// Usage:
//  - req_ channel: one word per payload byte, with first_item/last_item framing.
//    A first word starts a frame (command picks transmit request or AT command,
//    payload_length and at_code are read there); a last word closes it.
//  - rsp_ channel: one frame byte per word; frame_last marks the checksum byte,
//    length_mismatch flags it when the data count differs from the declared one.
//  - csr_ port: 64-bit APB-style registers at byte offsets 0 (destination),
//    8 (network address), 16 (transmit frame id), 24 (AT frame id). Write only
//    while idle. pready is tied high.
// Timing: while rsp_ready holds, the back end emits one byte per cycle from the
//  output register and plain data words sustain one per cycle; header words set
//  the pace. A word yields 1 to 19 bytes (17 header bytes, data, checksum); its
//  first byte passes the queue, the current-word register, then the output register.
// Stall: a two-word queue decouples input from output, so input words are
//  still taken while a byte waits on rsp_ready; when the queue fills req_ready
//  drops. A stalled byte holds in the output register.
// Reset: synchronous; clears frame state, empties the queue and restores the
//  register defaults.
`include "assert_macros.svh"

module radio_api_frame_builder
   import rafb_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_command,
   input  logic                   req_first_item,
   input  logic                   req_last_item,
   input  logic                   req_has_data,
   input  logic [LEN_W-1:0]       req_payload_length,
   input  logic [15:0]            req_at_code,
   input  logic [7:0]             req_data_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_frame_last,
   output logic                   rsp_length_mismatch,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [63:0]            csr_pwdata,
   output logic [63:0]            csr_prdata,
   output logic                   csr_pready
);

   // Configuration registers; the back end reads them live, so the user must write
   // them only while no frame is in flight; the block itself does not enforce it.
   cfg_type        cfg_ff;
   reg_index_type  csr_idx;
   logic           csr_wr;

   q_ctrl_type     q_ctrl;
   q_status_type   q_status;
   entry_type      wr_entry;
   entry_type      rd_entry;

   assign csr_pready = 1'b1;
   assign csr_idx    = reg_index_type'(csr_paddr[4:3]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dest  <= DEST_RESET;
         cfg_ff.net   <= NET_RESET;
         cfg_ff.tx_id <= TX_ID_RESET;
         cfg_ff.at_id <= AT_ID_RESET;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_DEST:  cfg_ff.dest  <= csr_pwdata;
            REG_NET:   cfg_ff.net   <= csr_pwdata[15:0];
            REG_TX_ID: cfg_ff.tx_id <= csr_pwdata[7:0];
            REG_AT_ID: cfg_ff.at_id <= csr_pwdata[7:0];
            default:   cfg_ff       <= cfg_ff;
         endcase
      end
   end

   // Read back: zero-extend the narrow registers.
   always_comb begin
      case (csr_idx)
         REG_DEST:  csr_prdata = cfg_ff.dest;
         REG_NET:   csr_prdata = {48'h0, cfg_ff.net};
         REG_TX_ID: csr_prdata = {56'h0, cfg_ff.tx_id};
         REG_AT_ID: csr_prdata = {56'h0, cfg_ff.at_id};
         default:   csr_prdata = '0;
      endcase
   end

   // Front: take words, drop those outside a frame, classify the rest.
   rafb_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_command        (req_command),
      .req_first_item     (req_first_item),
      .req_last_item      (req_last_item),
      .req_has_data       (req_has_data),
      .req_payload_length (req_payload_length),
      .req_at_code        (req_at_code),
      .req_data_byte      (req_data_byte),
      .q_status           (q_status),
      .push               (q_ctrl.push),
      .entry              (wr_entry)
   );

   // Queue: absorb header bursts so input keeps flowing.
   rafb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (q_ctrl),
      .wr_entry (wr_entry),
      .rd_entry (rd_entry),
      .status   (q_status)
   );

   // Back: advance one byte per cycle whenever the output register frees up.
   rafb_back u_back (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg_ff),
      .q_status            (q_status),
      .q_entry             (rd_entry),
      .pop                 (q_ctrl.pop),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_out_byte        (rsp_out_byte),
      .rsp_frame_last      (rsp_frame_last),
      .rsp_length_mismatch (rsp_length_mismatch)
   );

   `ASSERT_IMPLIES(a_mis_on_last, rsp_valid && rsp_length_mismatch, rsp_frame_last)
   `ASSERT_ALWAYS(a_queue_sane, !(q_status.full && q_status.empty))
   `ASSERT_IMPLIES(a_push_on_accept, q_ctrl.push, req_valid && req_ready)
   `ASSERT_IMPLIES(a_pop_not_empty, q_ctrl.pop, !q_status.empty)

endmodule
